>>> design/biquad_iir_filter_unit_defines.svh
// Assertion macros for the biquad filter unit.
// Used by the RTL files that carry concurrent assertions; needs a signal named clock and reset.
`ifndef BIQUAD_IIR_FILTER_UNIT_DEFINES_SVH
`define BIQUAD_IIR_FILTER_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define BIQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define BIQ_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

>>> design/biq_pkg.sv
// Shared types and constants for the biquad filter unit.
// No dependencies.
`default_nettype none

package biq_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 28;
   localparam int COEF_BITS      = 32;
   localparam int HIST_BITS      = 32;
   localparam int PROD_BITS      = COEF_BITS + HIST_BITS;
   localparam int ACC_BITS       = PROD_BITS + 2;
   localparam int RND_BITS       = ACC_BITS - COEF_FRAC_BITS;
   localparam int NUM_REGS       = 5;
   localparam int CSR_INDEX_BITS = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_B0     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_B1     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_B2     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FEEDBACK_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FEEDBACK_A2 = 3'd4;

   // accumulator operations
   localparam logic [2:0] ACC_HOLD   = 3'd0;
   localparam logic [2:0] ACC_LOAD_X = 3'd1;
   localparam logic [2:0] ACC_SUB    = 3'd2;
   localparam logic [2:0] ACC_LOAD_P = 3'd3;
   localparam logic [2:0] ACC_ADD    = 3'd4;

   // multiplier data operand
   localparam logic [1:0] DATA_HIST_ONE = 2'd0;
   localparam logic [1:0] DATA_HIST_TWO = 2'd1;
   localparam logic [1:0] DATA_W        = 2'd2;

   localparam logic [COEF_BITS-1:0] COEF_ONE =
      {{(COEF_BITS-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic [2:0]                acc_op;
      logic [CSR_INDEX_BITS-1:0] coef_sel;
      logic [1:0]                data_sel;
      logic                      w_latch;
      logic                      y_load;
   } biq_ctrl_type;

endpackage

`default_nettype wire

>>> design/biq_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, wide accumulator,
// round-half-up and saturation. Depends on biq_pkg.
`default_nettype none

module biq_mac (
   input  wire logic                                      clock,
   input  wire logic [2:0]                                acc_op,
   input  wire logic signed [biq_pkg::COEF_BITS-1:0]      op_coef,
   input  wire logic signed [biq_pkg::HIST_BITS-1:0]      op_data,
   input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0]    sample,
   output      logic signed [biq_pkg::HIST_BITS-1:0]      w_sat,
   output      logic signed [biq_pkg::SAMPLE_BITS-1:0]    y_sat
);

   localparam int ACC_BITS = biq_pkg::ACC_BITS;
   localparam int RND_BITS = biq_pkg::RND_BITS;
   localparam int F        = biq_pkg::COEF_FRAC_BITS;
   localparam int HB       = biq_pkg::HIST_BITS;
   localparam int SB       = biq_pkg::SAMPLE_BITS;

   localparam logic [ACC_BITS-1:0] ROUND_HALF =
      {{(ACC_BITS-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

   logic signed [biq_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]           acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]           prod_ext;
   logic signed [ACC_BITS-1:0]           x_ext;
   logic [ACC_BITS-1:0]                  rnd_sum;
   logic signed [RND_BITS-1:0]           rnd_q;
   logic                                 w_fits;
   logic                                 y_fits;

   assign prod_in  = op_coef * op_data;
   assign prod_ext = ACC_BITS'(prod_ff);
   assign x_ext    = {{(ACC_BITS-SB-F){sample[SB-1]}}, sample, {F{1'b0}}};

   always_comb begin
      case (acc_op)
         biq_pkg::ACC_HOLD:   acc_in = acc_ff;
         biq_pkg::ACC_LOAD_X: acc_in = x_ext;
         biq_pkg::ACC_SUB:    acc_in = acc_ff - prod_ext;
         biq_pkg::ACC_LOAD_P: acc_in = prod_ext;
         biq_pkg::ACC_ADD:    acc_in = acc_ff + prod_ext;
         default:             acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // floor((acc + half) / 2^F), then clamp
   assign rnd_sum = acc_ff + ROUND_HALF;
   assign rnd_q   = rnd_sum[ACC_BITS-1:F];

   assign w_fits = (&rnd_q[RND_BITS-1:HB-1]) | ~(|rnd_q[RND_BITS-1:HB-1]);
   assign y_fits = (&rnd_q[RND_BITS-1:SB-1]) | ~(|rnd_q[RND_BITS-1:SB-1]);

   assign w_sat = w_fits ? rnd_q[HB-1:0]
                         : {rnd_q[RND_BITS-1], {(HB-1){~rnd_q[RND_BITS-1]}}};
   assign y_sat = y_fits ? rnd_q[SB-1:0]
                         : {rnd_q[RND_BITS-1], {(SB-1){~rnd_q[RND_BITS-1]}}};

endmodule

`default_nettype wire

>>> design/biq_seq.sv
// Step sequencer for the biquad filter unit: drives the shared MAC through
// the feedback and feedforward passes. Depends on biq_pkg.
`default_nettype none

module biq_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 out_free,
   output      logic                 busy,
   output      biq_pkg::biq_ctrl_type ctrl
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_FB1  = 4'd1;
   localparam logic [3:0] ST_FB2  = 4'd2;
   localparam logic [3:0] ST_FB3  = 4'd3;
   localparam logic [3:0] ST_W    = 4'd4;
   localparam logic [3:0] ST_FF0  = 4'd5;
   localparam logic [3:0] ST_FF1  = 4'd6;
   localparam logic [3:0] ST_FF2  = 4'd7;
   localparam logic [3:0] ST_FF3  = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      ctrl.acc_op   = biq_pkg::ACC_HOLD;
      ctrl.coef_sel = biq_pkg::REG_FEEDBACK_A1;
      ctrl.data_sel = biq_pkg::DATA_HIST_ONE;
      ctrl.w_latch  = 1'b0;
      ctrl.y_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.acc_op = biq_pkg::ACC_LOAD_X;
               state_in    = ST_FB1;
            end
         end
         ST_FB1: begin
            state_in = ST_FB2;
         end
         ST_FB2: begin
            ctrl.acc_op   = biq_pkg::ACC_SUB;
            ctrl.coef_sel = biq_pkg::REG_FEEDBACK_A2;
            ctrl.data_sel = biq_pkg::DATA_HIST_TWO;
            state_in      = ST_FB3;
         end
         ST_FB3: begin
            ctrl.acc_op = biq_pkg::ACC_SUB;
            state_in    = ST_W;
         end
         ST_W: begin
            ctrl.w_latch = 1'b1;
            state_in     = ST_FF0;
         end
         ST_FF0: begin
            ctrl.coef_sel = biq_pkg::REG_GAIN_B0;
            ctrl.data_sel = biq_pkg::DATA_W;
            state_in      = ST_FF1;
         end
         ST_FF1: begin
            ctrl.acc_op   = biq_pkg::ACC_LOAD_P;
            ctrl.coef_sel = biq_pkg::REG_GAIN_B1;
            ctrl.data_sel = biq_pkg::DATA_HIST_ONE;
            state_in      = ST_FF2;
         end
         ST_FF2: begin
            ctrl.acc_op   = biq_pkg::ACC_ADD;
            ctrl.coef_sel = biq_pkg::REG_GAIN_B2;
            ctrl.data_sel = biq_pkg::DATA_HIST_TWO;
            state_in      = ST_FF3;
         end
         ST_FF3: begin
            ctrl.acc_op = biq_pkg::ACC_ADD;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // wait here while the previous result is still held
            if (out_free) begin
               ctrl.y_load = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> design/biquad_iir_filter_unit.sv
// Biquad IIR filter unit, direct form II, Q4.28 coefficients, one shared MAC.
// rsp_valid rises after both passes over the shared MAC (later if the output is stalled).
// req_stall holds new samples off while busy: the single multiplier steps 5 products.
// Reset (synchronous): coefficients to b0 = 1.0, others 0; history cleared, no result held.
// Any coefficient write clears the history. Depends on biq_pkg, biq_mac, biq_seq.
`default_nettype none
`include "biquad_iir_filter_unit_defines.svh"

module biquad_iir_filter_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic                                   req_block_last,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic signed [biq_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output      logic                                   rsp_block_last_out,
   input  wire logic                                   csr_write_enable,
   input  wire logic [biq_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [biq_pkg::COEF_BITS-1:0]          csr_write_data
);

   localparam int CB = biq_pkg::COEF_BITS;
   localparam int HB = biq_pkg::HIST_BITS;
   localparam int SB = biq_pkg::SAMPLE_BITS;

   logic signed [CB-1:0] coef_ff [biq_pkg::NUM_REGS];
   logic signed [HB-1:0] hist_one_ff, hist_one_in;
   logic signed [HB-1:0] hist_two_ff, hist_two_in;
   logic signed [HB-1:0] w_ff, w_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] rsp_sample_ff, rsp_sample_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                  busy;
   logic                  start;
   logic                  out_free;
   logic                  csr_hit;
   biq_pkg::biq_ctrl_type ctrl;
   logic signed [CB-1:0]  op_coef;
   logic signed [HB-1:0]  op_data;
   logic signed [HB-1:0]  w_sat;
   logic signed [SB-1:0]  y_sat;

   assign req_stall = busy;
   assign start     = req_valid & ~busy;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign csr_hit   = csr_write_enable &
                      (csr_index < biq_pkg::CSR_INDEX_BITS'(biq_pkg::NUM_REGS));

   biq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   always_comb begin
      case (ctrl.coef_sel)
         biq_pkg::REG_GAIN_B0:     op_coef = coef_ff[0];
         biq_pkg::REG_GAIN_B1:     op_coef = coef_ff[1];
         biq_pkg::REG_GAIN_B2:     op_coef = coef_ff[2];
         biq_pkg::REG_FEEDBACK_A1: op_coef = coef_ff[3];
         biq_pkg::REG_FEEDBACK_A2: op_coef = coef_ff[4];
         default:                  op_coef = coef_ff[0];
      endcase
      case (ctrl.data_sel)
         biq_pkg::DATA_HIST_ONE: op_data = hist_one_ff;
         biq_pkg::DATA_HIST_TWO: op_data = hist_two_ff;
         biq_pkg::DATA_W:        op_data = w_ff;
         default:                op_data = hist_one_ff;
      endcase
   end

   biq_mac u_mac (
      .clock   (clock),
      .acc_op  (ctrl.acc_op),
      .op_coef (op_coef),
      .op_data (op_data),
      .sample  (req_sample_in),
      .w_sat   (w_sat),
      .y_sat   (y_sat)
   );

   always_comb begin
      w_in          = ctrl.w_latch ? w_sat : w_ff;
      last_in       = start ? req_block_last : last_ff;
      hist_one_in   = hist_one_ff;
      hist_two_in   = hist_two_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (ctrl.y_load) begin
         hist_two_in   = hist_one_ff;
         hist_one_in   = w_ff;
         rsp_valid_in  = 1'b1;
         rsp_sample_in = y_sat;
         rsp_last_in   = last_ff;
      end
      if (csr_hit) begin
         hist_one_in = '0;
         hist_two_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0]   <= biq_pkg::COEF_ONE;
         coef_ff[1]   <= '0;
         coef_ff[2]   <= '0;
         coef_ff[3]   <= '0;
         coef_ff[4]   <= '0;
         hist_one_ff  <= '0;
         hist_two_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_hit) begin
            coef_ff[csr_index] <= csr_write_data;
         end
         hist_one_ff  <= hist_one_in;
         hist_two_ff  <= hist_two_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff          <= w_in;
      last_ff       <= last_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_block_last_out = rsp_last_ff;

   `BIQ_ASSERT(a_busy_after_transfer, start |=> req_stall, "no stall after req transfer")
   `BIQ_NEVER(a_no_overwrite, ctrl.y_load && rsp_valid_ff && rsp_stall, "result overwritten")
   `BIQ_ASSERT(a_csr_clears_history, csr_hit |=> (hist_one_ff == '0) && (hist_two_ff == '0),
      "history not cleared by coefficient write")
   `BIQ_ASSERT(a_hist_shift, ctrl.y_load && !csr_hit |=> hist_two_ff == $past(hist_one_ff),
      "history not shifted")

endmodule

`default_nettype wire
